// File: design/dts_pkg.sv
`default_nettype none
package dts_pkg;
    localparam logic [10:0] ExpOnes64 = 11'h7FF;
    localparam logic [7:0] ExpOnes32 = 8'hFF;
    localparam logic [11:0] Bias = 12'd896;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_INF  = 2'd1,
        KIND_NAN  = 2'd2,
        KIND_NUM  = 2'd3
    } kind_t;

    // stage 1 to stage 2: classified operand
    typedef struct packed {
        logic        sign;
        kind_t       kind;
        logic        sub;
        logic [5:0]  shift;
        logic [7:0]  expo;
        logic [52:0] mant;
    } cls_t;

    // stage 2 to stage 3: aligned value with rounding bits
    typedef struct packed {
        logic        sign;
        kind_t       kind;
        logic        sub;
        logic [7:0]  expo;
        logic [24:0] top;
        logic        half;
        logic        sticky;
        logic [22:0] nan_frac;
    } aln_t;
endpackage
`default_nettype wire

// File: design/dts_classify.sv
`default_nettype none
module dts_classify (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         vin,
    input  wire logic [63:0]  d,
    output logic              vout,
    output dts_pkg::cls_t     cls
);
    logic          v_reg;
    dts_pkg::cls_t c_reg;
    dts_pkg::cls_t c_next;
    logic [10:0]   e64;
    logic [11:0]   e;

    always_comb
    begin
        e64 = d[62:52];
        e = {1'b0, e64} - dts_pkg::Bias;
        c_next.sign = d[63];
        c_next.mant = {1'b1, d[51:0]};
        c_next.sub = 1'b0;
        c_next.expo = e[7:0];
        c_next.shift = 6'd29;
        c_next.kind = dts_pkg::KIND_NUM;
        if (e64 == dts_pkg::ExpOnes64)
        begin
            c_next.kind = (d[51:0] == '0) ? dts_pkg::KIND_INF : dts_pkg::KIND_NAN;
        end
        else if (e64 == '0)
        begin
            c_next.kind = dts_pkg::KIND_ZERO;
        end
        else if (e64 >= 11'd1151)
        begin
            c_next.kind = dts_pkg::KIND_INF;
        end
        else if (e64 <= 11'd896)
        begin
            // shift = 30 - e = 926 - e64
            if (e64 < 11'd873)
                c_next.kind = dts_pkg::KIND_ZERO;
            c_next.sub = 1'b1;
            c_next.shift = 6'(11'd926 - e64);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    assign vout = v_reg;
    assign cls = c_reg;
endmodule
`default_nettype wire

// File: design/dts_align.sv
`default_nettype none
module dts_align (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      vin,
    input  dts_pkg::cls_t  cls,
    output logic           vout,
    output dts_pkg::aln_t  aln
);
    logic          v_reg;
    dts_pkg::aln_t a_reg;
    dts_pkg::aln_t a_next;
    logic [52:0]   low;
    logic [52:0]   mask;
    logic [52:0]   hb;

    always_comb
    begin
        mask = (53'd1 << cls.shift) - 53'd1;
        hb = 53'd1 << (cls.shift - 6'd1);
        low = cls.mant & mask;
        a_next.sign = cls.sign;
        a_next.kind = cls.kind;
        a_next.sub = cls.sub;
        a_next.expo = cls.expo;
        a_next.top = 25'(cls.mant >> cls.shift);
        a_next.half = (low & hb) != '0;
        a_next.sticky = (low & (mask >> 1)) != '0;
        a_next.nan_frac = cls.mant[51:29];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= a_next;
    end

    assign vout = v_reg;
    assign aln = a_reg;
endmodule
`default_nettype wire

// File: design/dts_round.sv
`default_nettype none
module dts_round (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      vin,
    input  dts_pkg::aln_t  aln,
    output logic           vout,
    output logic [31:0]    res
);
    logic        v_reg;
    logic [31:0] r_reg;
    logic [31:0] r_next;
    logic [24:0] k;
    logic [8:0]  eo;

    always_comb
    begin
        k = aln.top + 25'(aln.half && (aln.sticky || aln.top[0]));
        eo = {1'b0, aln.expo} + 9'd1;
        case (aln.kind)
            dts_pkg::KIND_ZERO: r_next = {aln.sign, 31'd0};
            dts_pkg::KIND_INF:  r_next = {aln.sign, dts_pkg::ExpOnes32, 23'd0};
            dts_pkg::KIND_NAN:
                r_next = {aln.sign, dts_pkg::ExpOnes32, 1'b1, aln.nan_frac[21:0]};
            dts_pkg::KIND_NUM:
            begin
                if (aln.sub)
                    r_next = k[23] ? {aln.sign, 8'd1, 23'd0} : {aln.sign, 8'd0, k[22:0]};
                else if (k[24])
                    r_next = (eo >= 9'd255) ? {aln.sign, dts_pkg::ExpOnes32, 23'd0}
                                            : {aln.sign, eo[7:0], 23'd0};
                else
                    r_next = {aln.sign, aln.expo, k[22:0]};
            end
            default: r_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= r_next;
    end

    assign vout = v_reg;
    assign res = r_reg;
endmodule
`default_nettype wire

// File: design/double_to_single_rne.sv
// channel  valid        ready        data
// input    valid        ready        double_bits[63:0]
// output   single_valid single_ready single_bits[31:0]
// three register stages: classify, align, round; one word per cycle while the output is taken.
// the whole pipe holds while the output word waits.
// ready is high whenever the last stage is empty or being drained.
// reset clears only the stage valid bits.
`default_nettype none
module double_to_single_rne (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [63:0] double_bits,
    output logic             single_valid,
    input  wire logic        single_ready,
    output logic [31:0]      single_bits
);
    logic          en;
    logic          v1;
    logic          v2;
    dts_pkg::cls_t cls;
    dts_pkg::aln_t aln;

    assign en = single_ready || !single_valid;
    assign ready = en;

    dts_classify u_cls (.clk(clk), .rst_n(rst_n), .en(en), .vin(valid),
        .d(double_bits), .vout(v1), .cls(cls));
    dts_align u_aln (.clk(clk), .rst_n(rst_n), .en(en), .vin(v1),
        .cls(cls), .vout(v2), .aln(aln));
    dts_round u_rnd (.clk(clk), .rst_n(rst_n), .en(en), .vin(v2),
        .aln(aln), .vout(single_valid), .res(single_bits));
endmodule
`default_nettype wire

// File: dv/double_to_single_checker.sv
`default_nettype none
module double_to_single_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    input  wire logic        ready,
    input  wire logic [63:0] double_bits,
    input  wire logic        single_valid,
    input  wire logic        single_ready,
    input  wire logic [31:0] single_bits,
    output int               fail_count,
    output int               pending
);
    logic [31:0] single_q[$];

    function automatic logic [31:0] narrow_rne(input logic [63:0] d);
        logic        s;
        logic [10:0] e64;
        logic [51:0] f64;
        logic [52:0] mant;
        logic [63:0] top, low, half, mask;
        int          e, sh;
        logic [31:0] sgn, inf;
        s = d[63];
        e64 = d[62:52];
        f64 = d[51:0];
        sgn = {s, 31'b0};
        inf = sgn | 32'h7F80_0000;
        if (e64 == dts_pkg::ExpOnes64)
        begin
            if (f64 == 0)
                return inf;
            return inf | {9'b0, f64[51:29]} | 32'h0040_0000;
        end
        if (e64 == 0)
            return sgn;
        e = int'(e64) - 1023 + 127;
        if (e >= 255)
            return inf;
        mant = {1'b1, f64};
        sh = (e > 0) ? 29 : 30 - e;
        if (sh > 53)
            return sgn;
        mask = (64'd1 << sh) - 1;
        half = 64'd1 << (sh - 1);
        top = {11'b0, mant} >> sh;
        low = {11'b0, mant} & mask;
        if (low > half || (low == half && top[0]))
            top = top + 1;
        if (e > 0)
        begin
            if (top[24])
            begin
                if (e + 1 >= 255)
                    return inf;
                return sgn | (32'(e + 1) << 23);
            end
            return sgn | (32'(e) << 23) | {9'b0, top[22:0]};
        end
        if (top[23])
            return sgn | 32'h0080_0000;
        return sgn | {9'b0, top[22:0]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = single_q.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid && ready)
                single_q.push_back(narrow_rne(double_bits));
            if (single_valid && single_ready)
            begin
                if (single_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", single_bits));
                else if (single_q[0] !== single_bits)
                begin
                    report_mismatch($sformatf("single_bits %h, want %h",
                        single_bits, single_q[0]));
                    void'(single_q.pop_front());
                end
                else
                    void'(single_q.pop_front());
            end
        end
    end
endmodule
`default_nettype wire

// File: dv/double_to_single_rne_test.sv
`default_nettype none
module double_to_single_rne_test;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        valid = 0;
    logic        ready;
    logic [63:0] double_bits = 0;
    logic        single_valid;
    logic        single_ready = 0;
    logic [31:0] single_bits;
    int          fail_count, pending;
    bit          hold_out = 0;
    bit          hold_done = 0;

    always #6 clk = ~clk;

    double_to_single_rne dut (.*);
    double_to_single_checker chk (.*);

    function automatic logic [63:0] pick_double();
        logic [63:0] r;
        int          k;
        r = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        case (k)
            0: r[62:52] = 11'(1023 - 126 - $urandom_range(0, 30)); // subnormal band
            1: r[62:52] = 11'(1023 + 127 - $urandom_range(0, 1));  // top binade
            2: r[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            3: r[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h0FFF_FFFF; // near tie
            4: r[62:52] = 11'(1023 - 150 + $urandom_range(0, 3) - 2);
            5: r[62:52] = 11'(1023 + $urandom_range(0, 120) - 60);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_double(input logic [63:0] d);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            valid <= 0;
            repeat (gap) @(posedge clk);
        end
        double_bits <= d;
        valid <= 1;
        do @(posedge clk); while (!ready);
    endtask

    // directed then random
    initial
    begin
        logic [63:0] dir[$];
        dir = '{64'h0, 64'h8000_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF,
                64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h7FF8_0000_0000_0000, 64'h47F0_0000_0000_0000,
                64'h47EF_FFFF_F000_0000, 64'hC7EF_FFFF_E000_0000,
                64'h3810_0000_0000_0000, 64'h380F_FFFF_F000_0000,
                64'h3690_0000_0000_0000, 64'h3680_0000_0000_0000,
                64'h3680_0000_0000_0001, 64'h3670_0000_0000_0000,
                64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
                64'h3FF0_0000_1000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir[i])
            send_double(dir[i]);
        valid <= 0;
        // drain fully once before the random part
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
        hold_out <= 1;
        for (int n = 0; n < 650; n++)
        begin
            if (n == 20)
                hold_out <= 0;
            send_double(pick_double());
        end
        valid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("double_to_single_rne_test OK");
        else
            $display("double_to_single_rne_test NOT OK");
        $finish;
    end

    // receiver: long hold at the start of the random part, then random stalls
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_out && !hold_done)
            begin
                single_ready <= 0;
                repeat (40) @(posedge clk);
                hold_done = 1;
            end
            if (single_valid && !single_ready && $urandom_range(0, 5) != 0)
            begin
                single_ready <= 1;
                do @(posedge clk); while (!single_valid);
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
                if (gap != 0)
                begin
                    single_ready <= 0;
                    repeat (gap) @(posedge clk);
                end
                single_ready <= 1;
            end
            else
                single_ready <= $urandom_range(0, 2) != 0;
        end
    end

    initial
    begin
        #2000000;
        $display("double_to_single_rne_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
design/dts_pkg.sv
design/dts_classify.sv
design/dts_align.sv
design/dts_round.sv
design/double_to_single_rne.sv
dv/double_to_single_checker.sv
dv/double_to_single_rne_test.sv
